// ----- src/uss_pkg.sv -----
// shared types and constants for the unique sorted set table
// no dependencies
package uss_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OP_W        = 3;
  localparam int PORT_VAL_W  = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;

  typedef logic [VALUE_WIDTH-1:0] entry_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_SORTED_INSERT = 3'd0,
    OP_INSERT_FRONT  = 3'd1,
    OP_INSERT_BACK   = 3'd2,
    OP_REMOVE_FRONT  = 3'd3,
    OP_REMOVE_BACK   = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // rule for where an insert lands in the chain
  typedef enum logic [1:0] {
    ORD_SORTED = 2'd0,
    ORD_FRONT  = 2'd1,
    ORD_BACK   = 2'd2,
    ORD_NONE   = 2'd3
  } order_t;

  typedef struct packed {
    logic   ins;
    logic   rm_front;
    logic   rm_back;
    order_t order;
  } cell_ctl_t;

endpackage

// ----- src/unique_sorted_set_table_top.sv -----
// top level of the unique sorted set table: request register, cell chain, result register
// depends on uss_pkg and uss_cell
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------------
//  request   | start in, busy out         | opcode, value
//  result    | done out (high per result) | status, count, front_value, back_value
//
// a request taken at one edge updates the cells at the next edge; its result
// is registered together with the cell update
// one request per cycle, sustained: busy is high only during reset
// the whole chain compares combinationally and all cells shift together, the ripple through all
// cells (insert point, duplicate and back-entry search) sets the clock period
// rst is synchronous and clears the occupied bits, the count and all strobes
// the receiver cannot stall, so results are never held back
module unique_sorted_set_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [31:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic [4:0]  count,
  output logic [31:0] front_value,
  output logic [31:0] back_value
);
  import uss_pkg::*;

  // request register
  logic            req_valid;
  logic [OP_W-1:0] req_op;
  entry_t          req_value;

  // chain wiring, one slot per cell plus the ends
  entry_t              cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY:0]   found_chain;
  logic [CAPACITY:0]   dup_chain;
  entry_t              back_chain [CAPACITY+1];

  cnt_t      entry_count;
  cnt_t      entry_count_next;
  status_t   status_next;
  cell_ctl_t ctl;
  logic      is_insert;
  logic      is_full;
  logic      is_empty;
  logic      is_dup;
  status_t   status_q;

  assign busy = rst;

  always_ff @(posedge clk) begin
    req_op    <= opcode;
    req_value <= entry_t'(value);
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  // chain ends: nothing before the first cell, an empty slot after the last
  assign found_chain[0] = 1'b0;
  assign dup_chain[0]   = 1'b0;
  assign back_chain[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    logic   left_v;
    entry_t right_e;
    logic   right_v;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_v = 1'b1;   // an insert always fills the first slot
    end else begin : g_mid_l
      assign left_e = cell_entry[i-1];
      assign left_v = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
      assign right_v = 1'b0;
    end else begin : g_mid_r
      assign right_e = cell_entry[i+1];
      assign right_v = cell_valid[i+1];
    end

    uss_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .value       (req_value),
      .left_entry  (left_e),
      .left_valid  (left_v),
      .right_entry (right_e),
      .right_valid (right_v),
      .found_in    (found_chain[i]),
      .dup_in      (dup_chain[i]),
      .back_in     (back_chain[i]),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .found_out   (found_chain[i+1]),
      .dup_out     (dup_chain[i+1]),
      .back_out    (back_chain[i+1])
    );
  end

  assign is_dup   = dup_chain[CAPACITY];
  assign is_full  = (entry_count == cnt_t'(CAPACITY));
  assign is_empty = (entry_count == '0);

  // decode the pending request into chain controls and a status
  always_comb begin
    ctl.ins          = 1'b0;
    ctl.rm_front     = 1'b0;
    ctl.rm_back      = 1'b0;
    ctl.order        = ORD_NONE;
    status_next      = ST_DONE;
    entry_count_next = entry_count;
    is_insert        = 1'b0;
    if (req_valid) begin
      unique case (req_op)
        OP_SORTED_INSERT: begin
          ctl.order = ORD_SORTED;
          is_insert = 1'b1;
        end
        OP_INSERT_FRONT: begin
          ctl.order = ORD_FRONT;
          is_insert = 1'b1;
        end
        OP_INSERT_BACK: begin
          ctl.order = ORD_BACK;
          is_insert = 1'b1;
        end
        OP_REMOVE_FRONT, OP_REMOVE_BACK: begin
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else begin
            ctl.rm_front     = (req_op == OP_REMOVE_FRONT);
            ctl.rm_back      = (req_op == OP_REMOVE_BACK);
            entry_count_next = entry_count - cnt_t'(1);
          end
        end
        default: begin
          // unused opcodes change nothing
        end
      endcase
      // duplicate check wins over the full check
      if (is_insert) begin
        priority if (is_dup) begin
          status_next = ST_DUP;
        end else if (is_full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins          = 1'b1;
          entry_count_next = entry_count + cnt_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      done        <= req_valid;
    end
  end

  // outputs read the cells after the update, ends are zero for an empty table
  assign status      = status_q;
  assign count       = COUNT_W'(entry_count);
  assign front_value = is_empty ? '0 : PORT_VAL_W'(cell_entry[0]);
  assign back_value  = is_empty ? '0 : PORT_VAL_W'(back_chain[CAPACITY]);

endmodule

// ----- src/uss_cell.sv -----
// one slot of the table chain: holds an entry and its occupied bit
// depends on uss_pkg
module uss_cell (
  input  logic              clk,
  input  logic              rst,
  input  uss_pkg::cell_ctl_t ctl,
  input  uss_pkg::entry_t   value,
  input  uss_pkg::entry_t   left_entry,
  input  logic              left_valid,
  input  uss_pkg::entry_t   right_entry,
  input  logic              right_valid,
  input  logic              found_in,
  input  logic              dup_in,
  input  uss_pkg::entry_t   back_in,
  output uss_pkg::entry_t   entry,
  output logic              valid,
  output logic              found_out,
  output logic              dup_out,
  output uss_pkg::entry_t   back_out
);
  import uss_pkg::*;

  logic   lt_eff;
  logic   sel;
  entry_t entry_next;
  logic   valid_next;

  // entry counts as "before" the insert point
  always_comb begin
    unique case (ctl.order)
      ORD_SORTED: lt_eff = valid && (entry < value);
      ORD_FRONT:  lt_eff = 1'b0;
      ORD_BACK:   lt_eff = valid;
      default:    lt_eff = 1'b1;
    endcase
  end

  assign sel       = !found_in && !lt_eff;
  assign found_out = found_in || sel;
  assign dup_out   = dup_in || (valid && (entry == value));
  assign back_out  = (valid && !right_valid) ? entry : back_in;

  // no control set means the slot holds
  always_comb begin
    entry_next = entry;
    valid_next = valid;
    if (ctl.ins) begin
      if (found_in) begin
        entry_next = left_entry;
      end else if (sel) begin
        entry_next = value;
      end
      valid_next = left_valid;
    end else if (ctl.rm_front) begin
      entry_next = right_entry;
      valid_next = right_valid;
    end else if (ctl.rm_back) begin
      valid_next = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

// ----- src/uss_checker.sv -----
// port-level checks for the unique sorted set table, bound to the top level
// depends on uss_pkg
module uss_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  opcode,
  input logic [31:0] value,
  input logic        done,
  input logic [1:0]  status,
  input logic [4:0]  count,
  input logic [31:0] front_value,
  input logic [31:0] back_value
);
  import uss_pkg::*;

  // every accepted request yields a result after the request and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted request produced no result");

  // an empty status always reports an empty table
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (count == 5'd0))
    else $error("empty status with nonzero count");

  // a full status means the table is at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == 5'(CAPACITY)))
    else $error("full status below capacity");

  // empty table shows zero ends
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (done && count == 5'd0) |-> (front_value == 32'd0 && back_value == 32'd0))
    else $error("empty table shows nonzero ends");

  // a single entry is both front and back
  a_single_ends: assert property (@(posedge clk) disable iff (rst)
    (done && count == 5'd1) |-> (front_value == back_value))
    else $error("single entry with different ends");

endmodule

bind unique_sorted_set_table_top uss_checker u_uss_checker (.*);

// ----- tb/unique_sorted_set_table_top_test.sv -----
// testbench for the unique sorted set table: directed requests, then random request
// phases with sender idling, every result checked against a shadow copy of the set
// depends on uss_pkg and unique_sorted_set_table_top
module unique_sorted_set_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import uss_pkg::*;

  // opcodes past the last named one do nothing but still answer
  localparam int FIRST_UNUSED_OP = OP_REMOVE_BACK + 1;
  localparam int LAST_UNUSED_OP  = 2**OP_W - 1;
  localparam int PHASE_REQUESTS  = 332;
  localparam int BURST_LEN       = 60;

  // one predicted result: status and what the table looks like after the request
  typedef struct {
    status_t                status;
    logic [COUNT_W-1:0]     count;
    logic [PORT_VAL_W-1:0]  front;
    logic [PORT_VAL_W-1:0]  back;
  } table_view_t;

  // shadow copy of the set plus the results still owed by the block
  class set_tracker;
    entry_t        held[CAPACITY];
    int unsigned   held_count;
    table_view_t   awaited[$];
    int unsigned   mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // a held value, so that inserts hit the duplicate check often
    function logic [PORT_VAL_W-1:0] held_value();
      if (held_count == 0) return $urandom;
      return held[$urandom_range(held_count - 1)];
    endfunction

    // update the shadow set for an accepted request and queue its result
    function void apply_request(logic [OP_W-1:0] op, logic [PORT_VAL_W-1:0] raw);
      entry_t      v;
      table_view_t r;
      bit          seen;
      int          pos;
      v = raw[VALUE_WIDTH-1:0];
      seen = 1'b0;
      r.status = ST_DONE;
      case (op)
        OP_SORTED_INSERT, OP_INSERT_FRONT, OP_INSERT_BACK: begin
          for (int i = 0; i < held_count; i++)
            if (held[i] == v) seen = 1'b1;
          // duplicate wins over full
          if (seen) begin
            r.status = ST_DUP;
          end else if (held_count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            if (op == OP_INSERT_FRONT) begin
              pos = 0;
            end else if (op == OP_INSERT_BACK) begin
              pos = held_count;
            end else begin
              // first entry not less than the value, order may already be broken
              pos = 0;
              while (pos < held_count && held[pos] < v) pos++;
            end
            for (int i = held_count; i > pos; i--) held[i] = held[i-1];
            held[pos] = v;
            held_count++;
          end
        end
        OP_REMOVE_FRONT, OP_REMOVE_BACK: begin
          if (held_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (op == OP_REMOVE_FRONT)
              for (int i = 0; i + 1 < held_count; i++) held[i] = held[i+1];
            held_count--;
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(held_count);
      r.front = (held_count > 0) ? held[0] : '0;
      r.back  = (held_count > 0) ? held[held_count - 1] : '0;
      awaited.insert(awaited.size(), r);
    endfunction

    task compare_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt,
                        logic [PORT_VAL_W-1:0] fv, logic [PORT_VAL_W-1:0] bv);
      table_view_t e;
      if (awaited.size() == 0) begin
        report("result with no request pending");
        return;
      end
      e = awaited[0];
      awaited.delete(0);
      if (st !== e.status)
        report($sformatf("status %0d, predicted %0d", st, e.status));
      if (cnt !== e.count)
        report($sformatf("count %0d, predicted %0d", cnt, e.count));
      if (fv !== e.front)
        report($sformatf("front_value %h, predicted %h", fv, e.front));
      if (bv !== e.back)
        report($sformatf("back_value %h, predicted %h", bv, e.back));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [OP_W-1:0]       opcode;
  logic [PORT_VAL_W-1:0] value;
  logic                  done;
  logic [STATUS_W-1:0]   status;
  logic [COUNT_W-1:0]    count;
  logic [PORT_VAL_W-1:0] front_value;
  logic [PORT_VAL_W-1:0] back_value;

  set_tracker shadow_set;

  // sender idle percentage per phase; the third phase is the receiver-stall
  // phase, which has no effect here since results cannot be held off
  int idle_pct[4] = '{0, 52, 0, 21};

  unique_sorted_set_table_top uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .value       (value),
    .done        (done),
    .status      (status),
    .count       (count),
    .front_value (front_value),
    .back_value  (back_value)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // results live for one cycle, so every strobe is checked at the edge that ends it
  always @(posedge clk) begin
    if (done === 1'b1)
      shadow_set.compare_result(status, count, front_value, back_value);
  end

  // present a request at a falling edge and hold it until an edge sees busy low;
  // start stays high on return so back-to-back requests need no re-raise
  task send_request(input logic [OP_W-1:0] op, input logic [PORT_VAL_W-1:0] v);
    start  = 1'b1;
    opcode = op;
    value  = v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    shadow_set.apply_request(op, v);
    @(negedge clk);
  endtask

  // idle with no request, payload scrambled so it is seen to be ignored
  task idle_cycle();
    start  = 1'b0;
    opcode = OP_W'($urandom);
    value  = $urandom;
    @(negedge clk);
  endtask

  // sender holds off until the block has answered everything taken so far
  task wait_for_results();
    start = 1'b0;
    while (shadow_set.awaited.size() != 0) @(negedge clk);
  endtask

  // random request; grow bursts fill the table up to full, shrink bursts drain it
  task random_request(input int idle, input bit grow);
    int                    roll;
    logic [OP_W-1:0]       op;
    logic [PORT_VAL_W-1:0] v;
    while (idle > 0 && $urandom_range(99) < idle) idle_cycle();
    roll = $urandom_range(99);
    if (roll < 3)
      op = OP_W'($urandom_range(LAST_UNUSED_OP, FIRST_UNUSED_OP));
    else if (roll < (grow ? 83 : 23))
      op = OP_W'($urandom_range(OP_INSERT_BACK, OP_SORTED_INSERT));
    else
      op = OP_W'($urandom_range(OP_REMOVE_BACK, OP_REMOVE_FRONT));
    roll = $urandom_range(99);
    if (roll < 25)
      v = shadow_set.held_value();
    else if (roll < 50)
      v = $urandom_range(31);
    else if (roll < 57)
      v = $urandom_range(1) ? '1 : '0;
    else
      v = $urandom;
    send_request(op, v);
  endtask

  initial begin
    shadow_set = new();
    rst    = 1'b1;
    start  = 1'b0;
    opcode = '0;
    value  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // removals and unused codes on the empty table
    send_request(OP_REMOVE_FRONT, $urandom);
    send_request(OP_REMOVE_BACK, $urandom);
    send_request(OP_W'(FIRST_UNUSED_OP), $urandom);
    send_request(OP_W'(FIRST_UNUSED_OP + 1), $urandom);
    send_request(OP_W'(LAST_UNUSED_OP), $urandom);
    // sorted inserts at the extremes, then a duplicate
    send_request(OP_SORTED_INSERT, 32'h8000_0000);
    send_request(OP_SORTED_INSERT, '0);
    send_request(OP_SORTED_INSERT, '1);
    send_request(OP_SORTED_INSERT, 32'h8000_0000);
    // end inserts that break the order, then a sorted insert into the broken order
    send_request(OP_INSERT_FRONT, 32'h1234_5678);
    send_request(OP_INSERT_BACK, 32'h0000_0001);
    send_request(OP_SORTED_INSERT, 32'h4000_0000);
    // duplicates through the end inserts, found away from the ends
    send_request(OP_INSERT_FRONT, '0);
    send_request(OP_INSERT_BACK, '1);
    send_request(OP_W'(LAST_UNUSED_OP), $urandom);
    // drain down to empty, last removal finds the table already empty
    send_request(OP_REMOVE_FRONT, $urandom);
    send_request(OP_REMOVE_BACK, $urandom);
    send_request(OP_REMOVE_FRONT, $urandom);
    send_request(OP_REMOVE_BACK, $urandom);
    send_request(OP_REMOVE_FRONT, $urandom);
    send_request(OP_REMOVE_BACK, $urandom);
    send_request(OP_REMOVE_BACK, $urandom);
    send_request(OP_INSERT_BACK, 32'h5555_AAAA);
    wait_for_results();

    // random phases, each one ends with the sender waiting out all results
    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < PHASE_REQUESTS; n++)
        random_request(idle_pct[p], ((n / BURST_LEN) % 2) == 0);
      wait_for_results();
    end

    // keep the clock running so a stray late strobe would still be caught
    repeat (4) @(negedge clk);
    if (shadow_set.mismatches == 0 && shadow_set.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
src/uss_pkg.sv
src/uss_cell.sv
src/unique_sorted_set_table_top.sv
src/uss_checker.sv
tb/unique_sorted_set_table_top_test.sv
